/* sv/snell_refraction_direction_top_defines.svh */
// assertion macros used by the port checker of the refraction block
// expects clk_i and rst_ni in the scope where a macro is used
`ifndef SNELL_REFRACTION_DIRECTION_TOP_DEFINES_SVH
`define SNELL_REFRACTION_DIRECTION_TOP_DEFINES_SVH

// consequent checked in the same cycle
`define SRD_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the next cycle
`define SRD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/srd_pkg.sv */
// shared types and constants of the snell refraction block
// used by the top level, its port checker and the bench, depends on nothing
package srd_pkg;

  localparam int DATA_W        = 16;
  localparam int ETA_FRAC_BITS = 12;
  localparam int CFG_IDX_W     = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NORMAL_X  = 2'd0,
    CFG_NORMAL_Y  = 2'd1,
    CFG_NORMAL_Z  = 2'd2,
    CFG_ETA_RATIO = 2'd3
  } cfg_idx_e;

  localparam logic signed [DATA_W-1:0] NORMAL_X_RST  = 16'sd0;
  localparam logic signed [DATA_W-1:0] NORMAL_Y_RST  = 16'sd0;
  localparam logic signed [DATA_W-1:0] NORMAL_Z_RST  = 16'sd16384;
  localparam logic        [DATA_W-1:0] ETA_RATIO_RST = 16'd4096;

endpackage

/* sv/snell_refraction_direction_top.sv */
// snell-law refraction of a direction vector through a configured surface
// fully pipelined datapath with a bit-per-stage square root, uses srd_pkg
//
// usage:
//   input channel: dir_x_i/dir_y_i/dir_z_i with in_valid_i, the block
//   drives in_stall_o; an item is taken when in_valid_i is high and
//   in_stall_o low. output channel: refracted_o and out_x_o/out_y_o/out_z_o
//   with out_valid_o, the receiver drives out_stall_i.
//   configuration: cfg_we_i writes cfg_data_i to the register picked by
//   cfg_idx_i (normal x, y, z, eta ratio); write only while no item is in
//   flight.
//   stages from acceptance to the output register: six stages for cosine,
//   squared sine and the transmitted squared sine, one stage per root bit
//   of the square root, four stages for the output vector.
//   throughput: one item per cycle while the output is not stalled.
//   stall: a stalled output freezes the whole pipeline, and in_stall_o is
//   high exactly while the output holds an item and out_stall_i is high.
//   reset: all valid bits clear, registers return to normal (0, 0, 1.0)
//   and ratio 1.0.
module snell_refraction_direction_top
  import srd_pkg::*;
#(
  parameter int DIR_FRAC_BITS = 14
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,

  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [DATA_W-1:0]        cfg_data_i,

  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic signed [DATA_W-1:0] dir_x_i,
  input  logic signed [DATA_W-1:0] dir_y_i,
  input  logic signed [DATA_W-1:0] dir_z_i,

  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic                     refracted_o,
  output logic signed [DATA_W-1:0] out_x_o,
  output logic signed [DATA_W-1:0] out_y_o,
  output logic signed [DATA_W-1:0] out_z_o
);

  localparam int F     = DIR_FRAC_BITS;
  localparam int DW    = DATA_W;
  localparam int EF    = ETA_FRAC_BITS;
  localparam int PW    = 2 * DW;
  localparam int DOTW  = PW + 2;
  localparam int CW    = DOTW - F;
  localparam int CCW   = 2 * CW;
  localparam int S2W   = ((CCW > 2 * F + 1) ? CCW : 2 * F + 1) + 1;
  localparam int E2W   = 2 * DW;
  localparam int TPW   = E2W + F + 1;
  localparam int T2W   = TPW + 1 - 2 * EF;
  localparam int CTW   = F + 1;
  localparam int SQW   = 2 * F + 3;
  localparam int ECW   = DW + 1 + CW;
  localparam int CTSW  = F + 2 + EF;
  localparam int KW    = ((ECW > CTSW) ? ECW : CTSW) + 1;
  localparam int KNW   = KW + DW;
  localparam int EWW   = 2 * DW + 1;
  localparam int SW    = ((KNW > EWW + F) ? KNW : EWW + F) + 1;
  localparam int SH    = F + EF;
  localparam int RSW   = SW + 1 - SH;

  localparam logic [DOTW:0]    DOT_HALF = (DOTW + 1)'(1) << (F - 1);
  localparam logic [S2W-1:0]   ONE2     = S2W'(1) << (2 * F);
  localparam logic [2*F:0]     S2_HALF  = (2 * F + 1)'(1) << (F - 1);
  localparam logic [TPW:0]     T2_HALF  = (TPW + 1)'(1) << (2 * EF - 1);
  localparam logic [T2W-1:0]   T2_ONE   = T2W'(1) << F;
  localparam logic [SW:0]      OUT_HALF = (SW + 1)'(1) << (SH - 1);
  localparam logic signed [RSW-1:0] SAT_MAX = RSW'((2 ** (DW - 1)) - 1);
  localparam logic signed [RSW-1:0] SAT_MIN = ~SAT_MAX;

  typedef struct packed {
    logic signed [DW-1:0] x;
    logic signed [DW-1:0] y;
    logic signed [DW-1:0] z;
  } vec_t;

  typedef struct packed {
    logic                 tir;
    logic signed [CW-1:0] c;
    vec_t                 w;
    logic [CTW-1:0]       res;
    logic [SQW-1:0]       rem;
  } sq_t;

  // round half away from zero by SH bits, then saturate
  function automatic logic [DW-1:0] rnd_sat(input logic signed [SW-1:0] x);
    logic [SW:0]            t;
    logic signed [RSW-1:0]  r;
    t = {x[SW-1], x} + OUT_HALF - (SW + 1)'(x[SW-1]);
    r = t[SW:SH];
    if (r > SAT_MAX) begin
      return SAT_MAX[DW-1:0];
    end else if (r < SAT_MIN) begin
      return SAT_MIN[DW-1:0];
    end
    return r[DW-1:0];
  endfunction

  // configuration registers
  logic signed [DW-1:0] normal_x_q, normal_y_q, normal_z_q;
  logic [DW-1:0]        eta_q;
  logic signed [DW:0]   eta_s;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      normal_x_q <= NORMAL_X_RST;
      normal_y_q <= NORMAL_Y_RST;
      normal_z_q <= NORMAL_Z_RST;
      eta_q      <= ETA_RATIO_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_NORMAL_X:  normal_x_q <= cfg_data_i;
        CFG_NORMAL_Y:  normal_y_q <= cfg_data_i;
        CFG_NORMAL_Z:  normal_z_q <= cfg_data_i;
        CFG_ETA_RATIO: eta_q      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign eta_s = $signed({1'b0, eta_q});

  // global advance: the pipeline moves unless a finished item is held
  logic en;
  logic out_valid_q;
  assign en         = !out_valid_q || !out_stall_i;
  assign in_stall_o = !en;

  // stage 1: dot product terms
  logic                 v1_q;
  vec_t                 w1_q;
  logic signed [PW-1:0] px1_d, py1_d, pz1_d, px1_q, py1_q, pz1_q;

  always_comb begin
    px1_d = dir_x_i * normal_x_q;
    py1_d = dir_y_i * normal_y_q;
    pz1_d = dir_z_i * normal_z_q;
  end

  // stage 2: rounded cosine
  logic                 v2_q;
  vec_t                 w2_q;
  logic signed [DOTW-1:0] dot2;
  logic [DOTW:0]        dotr2;
  logic signed [CW-1:0] c2_d, c2_q;

  always_comb begin
    dot2  = DOTW'(px1_q) + DOTW'(py1_q) + DOTW'(pz1_q);
    dotr2 = {dot2[DOTW-1], dot2} + DOT_HALF - (DOTW + 1)'(dot2[DOTW-1]);
    c2_d  = dotr2[F+CW-1:F];
  end

  // stage 3: squared cosine
  logic                  v3_q;
  vec_t                  w3_q;
  logic signed [CW-1:0]  c3_q;
  logic signed [CCW-1:0] cc3_d, cc3_q;

  assign cc3_d = c2_q * c2_q;

  // stage 4: squared sine with clamp and rounding, squared ratio
  logic                 v4_q;
  vec_t                 w4_q;
  logic signed [CW-1:0] c4_q;
  logic [S2W-1:0]       s2w4;
  logic [2*F:0]         s2u4, s2r4;
  logic [F:0]           s2f4_d, s2f4_q;
  logic [E2W-1:0]       eta2_4_d, eta2_4_q;

  always_comb begin
    s2w4     = ONE2 - S2W'(cc3_q);
    s2u4     = s2w4[S2W-1] ? '0 : s2w4[2*F:0];
    s2r4     = s2u4 + S2_HALF;
    s2f4_d   = s2r4[2*F:F];
    eta2_4_d = eta_q * eta_q;
  end

  // stage 5: transmitted squared sine, unrounded
  logic                 v5_q;
  vec_t                 w5_q;
  logic signed [CW-1:0] c5_q;
  logic [TPW-1:0]       tp5_d, tp5_q;

  assign tp5_d = eta2_4_q * s2f4_q;

  // stage 6: reflection test and radicand
  logic [TPW:0]   t2s6;
  logic [T2W-1:0] t2_6;
  logic [T2W-1:0] rem6;
  sq_t            sq0_d;

  always_comb begin
    t2s6        = {1'b0, tp5_q} + T2_HALF;
    t2_6        = t2s6[TPW:2*EF];
    rem6        = T2_ONE - t2_6;
    sq0_d.tir   = t2_6 > T2_ONE;
    sq0_d.c     = c5_q;
    sq0_d.w     = w5_q;
    sq0_d.res   = '0;
    sq0_d.rem   = SQW'(rem6[F:0]) << F;
  end

  // square root, one result bit per stage from the top bit down
  logic           sqv_q [F+2];
  sq_t            sq_q  [F+2];
  sq_t            sq_d  [F+1];
  logic [SQW-1:0] sq_dlt;

  always_comb begin
    sq_dlt = '0;
    for (int i = 0; i <= F; i++) begin
      sq_d[i] = sq_q[i];
      sq_dlt  = (SQW'(sq_q[i].res) << (F - i + 1)) + (SQW'(1) << (2 * (F - i)));
      if (sq_q[i].rem >= sq_dlt) begin
        sq_d[i].rem = sq_q[i].rem - sq_dlt;
        sq_d[i].res = sq_q[i].res | (CTW'(1) << (F - i));
      end
    end
  end

  // stage a: k = eta*c - cT, and eta*w
  logic                  va_q, tira_q;
  logic signed [ECW-1:0] eca;
  logic signed [CTSW-1:0] ctsa;
  logic signed [KW-1:0]  ka_d, ka_q;
  logic signed [EWW-1:0] ewxa_d, ewya_d, ewza_d, ewxa_q, ewya_q, ewza_q;

  always_comb begin
    eca    = eta_s * sq_q[F+1].c;
    ctsa   = $signed({1'b0, sq_q[F+1].res, {EF{1'b0}}});
    ka_d   = KW'(eca) - KW'(ctsa);
    ewxa_d = eta_s * $signed(sq_q[F+1].w.x);
    ewya_d = eta_s * $signed(sq_q[F+1].w.y);
    ewza_d = eta_s * $signed(sq_q[F+1].w.z);
  end

  // stage b: k*N
  logic                  vb_q, tirb_q;
  logic signed [KNW-1:0] knxb_d, knyb_d, knzb_d, knxb_q, knyb_q, knzb_q;
  logic signed [EWW-1:0] ewxb_q, ewyb_q, ewzb_q;

  always_comb begin
    knxb_d = ka_q * normal_x_q;
    knyb_d = ka_q * normal_y_q;
    knzb_d = ka_q * normal_z_q;
  end

  // stage c: full-precision refracted vector
  logic                 vc_q, tirc_q;
  logic signed [SW-1:0] sxc_d, syc_d, szc_d, sxc_q, syc_q, szc_q;

  always_comb begin
    sxc_d = SW'(knxb_q) - (SW'(ewxb_q) <<< F);
    syc_d = SW'(knyb_q) - (SW'(ewyb_q) <<< F);
    szc_d = SW'(knzb_q) - (SW'(ewzb_q) <<< F);
  end

  // stage d: output register
  logic                 refracted_q;
  logic signed [DW-1:0] out_x_q, out_y_q, out_z_q;

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      v4_q        <= 1'b0;
      v5_q        <= 1'b0;
      for (int j = 0; j < F + 2; j++) begin
        sqv_q[j] <= 1'b0;
      end
      va_q        <= 1'b0;
      vb_q        <= 1'b0;
      vc_q        <= 1'b0;
      out_valid_q <= 1'b0;
      refracted_q <= 1'b0;
    end else if (en) begin
      v1_q     <= in_valid_i;
      v2_q     <= v1_q;
      v3_q     <= v2_q;
      v4_q     <= v3_q;
      v5_q     <= v4_q;
      sqv_q[0] <= v5_q;
      for (int j = 1; j < F + 2; j++) begin
        sqv_q[j] <= sqv_q[j-1];
      end
      va_q        <= sqv_q[F+1];
      vb_q        <= va_q;
      vc_q        <= vb_q;
      out_valid_q <= vc_q;
      refracted_q <= !tirc_q;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (en) begin
      w1_q     <= '{x: dir_x_i, y: dir_y_i, z: dir_z_i};
      px1_q    <= px1_d;
      py1_q    <= py1_d;
      pz1_q    <= pz1_d;
      w2_q     <= w1_q;
      c2_q     <= c2_d;
      w3_q     <= w2_q;
      c3_q     <= c2_q;
      cc3_q    <= cc3_d;
      w4_q     <= w3_q;
      c4_q     <= c3_q;
      s2f4_q   <= s2f4_d;
      eta2_4_q <= eta2_4_d;
      w5_q     <= w4_q;
      c5_q     <= c4_q;
      tp5_q    <= tp5_d;
      sq_q[0]  <= sq0_d;
      for (int j = 0; j <= F; j++) begin
        sq_q[j+1] <= sq_d[j];
      end
      tira_q   <= sq_q[F+1].tir;
      ka_q     <= ka_d;
      ewxa_q   <= ewxa_d;
      ewya_q   <= ewya_d;
      ewza_q   <= ewza_d;
      tirb_q   <= tira_q;
      knxb_q   <= knxb_d;
      knyb_q   <= knyb_d;
      knzb_q   <= knzb_d;
      ewxb_q   <= ewxa_q;
      ewyb_q   <= ewya_q;
      ewzb_q   <= ewza_q;
      tirc_q   <= tirb_q;
      sxc_q    <= sxc_d;
      syc_q    <= syc_d;
      szc_q    <= szc_d;
      // reflection gives a zero vector
      out_x_q  <= tirc_q ? '0 : rnd_sat(sxc_q);
      out_y_q  <= tirc_q ? '0 : rnd_sat(syc_q);
      out_z_q  <= tirc_q ? '0 : rnd_sat(szc_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign refracted_o = refracted_q;
  assign out_x_o     = out_x_q;
  assign out_y_o     = out_y_q;
  assign out_z_o     = out_z_q;

endmodule

/* sv/srd_checker.sv */
// port-level checker for the snell refraction block, bound to the top level
// depends on srd_pkg and the shared assertion macro header
`include "snell_refraction_direction_top_defines.svh"

module srd_checker
  import srd_pkg::*;
(
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_valid_i,
  input logic                     in_stall_o,
  input logic                     out_valid_o,
  input logic                     out_stall_i,
  input logic                     refracted_o,
  input logic signed [DATA_W-1:0] out_x_o,
  input logic signed [DATA_W-1:0] out_y_o,
  input logic signed [DATA_W-1:0] out_z_o
);

  // a held result keeps its payload
  `SRD_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(refracted_o) && $stable(out_x_o) && $stable(out_y_o) && $stable(out_z_o), "held item changed")

  // reflection reports a zero vector
  `SRD_ASSERT_SAME(a_tir_zero, out_valid_o && !refracted_o, out_x_o == '0 && out_y_o == '0 && out_z_o == '0, "reflection with nonzero vector")

  // input only stalls behind a held result
  `SRD_ASSERT_SAME(a_stall_cause, in_stall_o, out_valid_o && out_stall_i, "input stalled without held output")

  // a free output register never blocks the input
  `SRD_ASSERT_SAME(a_no_stall_idle, !out_valid_o || !out_stall_i, !in_stall_o, "input stalled while output free")

endmodule

bind snell_refraction_direction_top srd_checker u_srd_checker (.*);

/* bench/snell_refraction_direction_top_tb.sv */
// self-checking bench for snell_refraction_direction_top: directed and random directions
// under several surface settings, with random idling on both channels
// depends on srd_pkg and the top level only
module snell_refraction_direction_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import srd_pkg::*;

  localparam int FRAC      = 14;
  localparam int WDOG_MAX  = 2000;
  localparam int TAIL_WAIT = 40;

  typedef struct {
    logic                     refr;
    logic signed [DATA_W-1:0] x;
    logic signed [DATA_W-1:0] y;
    logic signed [DATA_W-1:0] z;
  } ray_t;

  class refraction_scoreboard;
    logic signed [DATA_W-1:0] nrm_x;
    logic signed [DATA_W-1:0] nrm_y;
    logic signed [DATA_W-1:0] nrm_z;
    logic        [DATA_W-1:0] eta;
    ray_t expected_rays[$];
    int   fails;

    function new();
      nrm_x = NORMAL_X_RST;
      nrm_y = NORMAL_Y_RST;
      nrm_z = NORMAL_Z_RST;
      eta   = ETA_RATIO_RST;
      fails = 0;
    endfunction

    function void set_reg(cfg_idx_e idx, logic [DATA_W-1:0] v);
      case (idx)
        CFG_NORMAL_X:  nrm_x = v;
        CFG_NORMAL_Y:  nrm_y = v;
        CFG_NORMAL_Z:  nrm_z = v;
        CFG_ETA_RATIO: eta   = v;
        default: ;
      endcase
    endfunction

    // divide by 2^s, ties away from zero
    function longint round_away(longint v, int s);
      longint half;
      half = longint'(1) <<< (s - 1);
      if (v < 0) return -((-v + half) >>> s);
      return (v + half) >>> s;
    endfunction

    function longint floor_sqrt(longint v);
      longint r;
      longint t;
      r = 0;
      for (int b = 16; b >= 0; b--) begin
        t = r | (longint'(1) <<< b);
        if (t * t <= v) r = t;
      end
      return r;
    endfunction

    function logic signed [DATA_W-1:0] clip16(longint v);
      if (v > 32767) return 16'sh7fff;
      if (v < -32768) return 16'sh8000;
      return v[DATA_W-1:0];
    endfunction

    function ray_t refract(logic signed [DATA_W-1:0] dx, logic signed [DATA_W-1:0] dy,
                           logic signed [DATA_W-1:0] dz);
      longint wx, wy, wz, nx, ny, nz, e, one;
      longint cosv, s2, s2f, t2, ct, k;
      ray_t r;
      wx = longint'(dx); wy = longint'(dy); wz = longint'(dz);
      nx = longint'(nrm_x); ny = longint'(nrm_y); nz = longint'(nrm_z);
      e = longint'(eta);
      one = longint'(1) <<< FRAC;
      cosv = round_away(wx * nx + wy * ny + wz * nz, FRAC);
      s2 = (longint'(1) <<< (2 * FRAC)) - cosv * cosv;
      if (s2 < 0) s2 = 0;
      s2f = (s2 + (longint'(1) <<< (FRAC - 1))) >>> FRAC;
      t2 = (e * e * s2f + (longint'(1) <<< (2 * ETA_FRAC_BITS - 1))) >>> (2 * ETA_FRAC_BITS);
      r = '{refr: 1'b0, x: '0, y: '0, z: '0};
      if (t2 > one) return r;  // total internal reflection
      ct = floor_sqrt((one - t2) <<< FRAC);
      k = e * cosv - ct * (longint'(1) <<< ETA_FRAC_BITS);
      r.refr = 1'b1;
      r.x = clip16(round_away(-(e * wx) * one + k * nx, FRAC + ETA_FRAC_BITS));
      r.y = clip16(round_away(-(e * wy) * one + k * ny, FRAC + ETA_FRAC_BITS));
      r.z = clip16(round_away(-(e * wz) * one + k * nz, FRAC + ETA_FRAC_BITS));
      return r;
    endfunction

    function void note_dir(logic signed [DATA_W-1:0] dx, logic signed [DATA_W-1:0] dy,
                           logic signed [DATA_W-1:0] dz);
      expected_rays.push_back(refract(dx, dy, dz));
    endfunction

    function void check_result(ray_t got);
      ray_t want;
      if (expected_rays.size() == 0) begin
        $error("result item with nothing expected");
        fails++;
        return;
      end
      want = expected_rays.pop_front();
      if (got.refr !== want.refr) begin
        $error("refracted expected %0d got %0d", want.refr, got.refr);
        fails++;
      end
      if (got.x !== want.x) begin
        $error("out_x expected %0d got %0d", want.x, got.x);
        fails++;
      end
      if (got.y !== want.y) begin
        $error("out_y expected %0d got %0d", want.y, got.y);
        fails++;
      end
      if (got.z !== want.z) begin
        $error("out_z expected %0d got %0d", want.z, got.z);
        fails++;
      end
    endfunction

    function int pending();
      return expected_rays.size();
    endfunction
  endclass

  logic                     clk_i;
  logic                     rst_ni     = 1'b0;
  logic                     cfg_we_i   = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_idx_i  = '0;
  logic [DATA_W-1:0]        cfg_data_i = '0;
  logic                     in_valid_i = 1'b0;
  logic                     in_stall_o;
  logic signed [DATA_W-1:0] dir_x_i    = '0;
  logic signed [DATA_W-1:0] dir_y_i    = '0;
  logic signed [DATA_W-1:0] dir_z_i    = '0;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  logic                     refracted_o;
  logic signed [DATA_W-1:0] out_x_o;
  logic signed [DATA_W-1:0] out_y_o;
  logic signed [DATA_W-1:0] out_z_o;

  refraction_scoreboard sb;
  int gap_pct   = 0;
  int stall_pct = 0;
  int idle_cycles = 0;

  snell_refraction_direction_top dut (
    .clk_i, .rst_ni,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_stall_o, .dir_x_i, .dir_y_i, .dir_z_i,
    .out_valid_o, .out_stall_i, .refracted_o, .out_x_o, .out_y_o, .out_z_o
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // receiver stalls in bursts
  initial begin
    forever begin
      @(posedge clk_i);
      if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 19)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // both handshakes are sampled before the edge updates anything
  always @(posedge clk_i) begin
    if (rst_ni && sb != null) begin
      if (in_valid_i && !in_stall_o) sb.note_dir(dir_x_i, dir_y_i, dir_z_i);
      if (out_valid_o && !out_stall_i)
        sb.check_result('{refr: refracted_o, x: out_x_o, y: out_y_o, z: out_z_o});
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WDOG_MAX) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  task automatic send_dir(logic signed [DATA_W-1:0] x, logic signed [DATA_W-1:0] y,
                          logic signed [DATA_W-1:0] z);
    in_valid_i <= 1'b1;
    dir_x_i    <= x;
    dir_y_i    <= y;
    dir_z_i    <= z;
    do @(posedge clk_i); while (in_stall_o);
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [DATA_W-1:0] v);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= v;
    @(posedge clk_i);
    sb.set_reg(idx, v);
  endtask

  task automatic set_surface(logic [DATA_W-1:0] nx, logic [DATA_W-1:0] ny,
                             logic [DATA_W-1:0] nz, logic [DATA_W-1:0] e);
    write_reg(CFG_NORMAL_X, nx);
    write_reg(CFG_NORMAL_Y, ny);
    write_reg(CFG_NORMAL_Z, nz);
    write_reg(CFG_ETA_RATIO, e);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // sender holds off until the pipeline has handed back everything
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic random_unit(output logic signed [DATA_W-1:0] x,
                             output logic signed [DATA_W-1:0] y,
                             output logic signed [DATA_W-1:0] z);
    real vx, vy, vz, len;
    vx = (real'($urandom_range(0, 65536)) - 32768.0) / 32768.0;
    vy = (real'($urandom_range(0, 65536)) - 32768.0) / 32768.0;
    vz = (real'($urandom_range(0, 65536)) - 32768.0) / 32768.0;
    len = $sqrt(vx * vx + vy * vy + vz * vz);
    if (len < 1.0e-3) begin
      vz = 1.0;
      len = 1.0;
    end
    x = 16'($rtoi(vx / len * 16384.0));
    y = 16'($rtoi(vy / len * 16384.0));
    z = 16'($rtoi(vz / len * 16384.0));
  endtask

  function automatic logic [DATA_W-1:0] pick_extreme();
    case ($urandom_range(0, 4))
      0: return 16'h8000;
      1: return -16'sd16384;
      2: return 16'h0000;
      3: return 16'd16384;
      default: return 16'h7fff;
    endcase
  endfunction

  task automatic random_surface();
    logic signed [DATA_W-1:0] nx, ny, nz;
    logic [DATA_W-1:0] e;
    case ($urandom_range(0, 5))
      0, 1, 2: random_unit(nx, ny, nz);
      3: begin
        nx = '0; ny = '0; nz = '0;
        case ($urandom_range(0, 2))
          0: nx = $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
          1: ny = $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
          default: nz = $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
        endcase
      end
      4: begin
        nx = 16'($urandom()); ny = 16'($urandom()); nz = 16'($urandom());
      end
      default: begin
        nx = pick_extreme(); ny = pick_extreme(); nz = pick_extreme();
      end
    endcase
    case ($urandom_range(0, 7))
      0, 1: e = 16'($urandom_range(3500, 4700));
      2, 3, 4: e = 16'($urandom_range(2048, 8192));
      5: e = $urandom_range(0, 1) ? 16'd0 : 16'hffff;
      default: e = 16'($urandom());
    endcase
    set_surface(nx, ny, nz, e);
  endtask

  task automatic random_dir();
    logic signed [DATA_W-1:0] x, y, z;
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 6) begin
      random_unit(x, y, z);
    end else if (sel < 8) begin
      x = 16'($urandom()); y = 16'($urandom()); z = 16'($urandom());
    end else begin
      // near the normal or its opposite, small perturbation
      x = sb.nrm_x + $signed(16'($urandom_range(0, 64)) - 16'sd32);
      y = sb.nrm_y + $signed(16'($urandom_range(0, 64)) - 16'sd32);
      z = sb.nrm_z + $signed(16'($urandom_range(0, 64)) - 16'sd32);
      if ($urandom_range(0, 1)) begin
        x = -x; y = -y; z = -z;
      end
    end
    send_dir(x, y, z);
  endtask

  initial begin
    int n_phases;
    sb = new();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset surface: normal +z, unit ratio
    send_dir(16'sd0, 16'sd0, 16'sd16384);
    send_dir(16'sd0, 16'sd0, -16'sd16384);
    send_dir(16'sd16384, 16'sd0, 16'sd0);
    send_dir(16'sd0, -16'sd16384, 16'sd0);
    send_dir(16'sd11585, 16'sd0, 16'sd11585);
    send_dir(16'sd0, 16'sd0, 16'sd0);
    send_dir(16'sh7fff, 16'sh7fff, 16'sh7fff);
    send_dir(16'sh8000, 16'sh8000, 16'sh8000);
    send_dir(-16'sd1, 16'sd1, -16'sd1);
    drain_results();

    // ratio 1.5: grazing and 45 degrees reflect, shallow angles pass
    set_surface(16'd0, 16'd0, 16'd16384, 16'd6144);
    send_dir(16'sd16384, 16'sd0, 16'sd0);
    send_dir(16'sd11585, 16'sd0, 16'sd11585);
    send_dir(16'sd8192, 16'sd0, 16'sd14189);
    send_dir(16'sd0, 16'sd0, 16'sd16384);
    drain_results();

    // largest ratio
    set_surface(16'd0, 16'd0, 16'd16384, 16'hffff);
    send_dir(16'sd0, 16'sd0, 16'sd16384);
    send_dir(16'sd1, 16'sd0, 16'sd16384);
    send_dir(16'sd16384, 16'sd0, 16'sd0);
    drain_results();

    // zero ratio gives the negated normal
    set_surface(-16'sd16384, 16'sd16384, -16'sd16384, 16'd0);
    send_dir(16'sd12345, -16'sd222, 16'sd3);
    send_dir(16'sh8000, 16'sh7fff, 16'sd0);
    drain_results();

    // out-of-range normal, unit ratio
    set_surface(16'h7fff, 16'h8000, 16'd16384, 16'd4096);
    send_dir(16'sd16384, 16'sd16384, 16'sd0);
    send_dir(16'sh8000, 16'sd0, 16'sh7fff);
    send_dir(16'sd0, 16'sd0, 16'sd16384);
    drain_results();

    n_phases = 13;
    for (int p = 0; p < n_phases; p++) begin
      random_surface();
      if (p == n_phases - 1) begin
        gap_pct = 0;
        stall_pct = 0;
      end else begin
        gap_pct   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 30);
        stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 30);
      end
      repeat ($urandom_range(90, 110)) random_dir();
      drain_results();
    end

    repeat (TAIL_WAIT) @(posedge clk_i);
    if (sb.fails == 0 && sb.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
